>>> sv/frwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwa_pkg
// Shared types and codes of the fair readers-writers admission arbiter:
// the item structs of both channels, the operation and status codes, and the
// control structs between the top level and the occupancy table.
// ----------------------------------------------------------------------------
package frwa_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_DEPART = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_QFULL    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_TFULL    = 2'd3;

  // Requester kinds.
  localparam logic KIND_READER = 1'b0;
  localparam logic KIND_WRITER = 1'b1;

  // Input item.
  typedef struct packed {
    logic [1:0] operation;
    logic       entrant_kind;
    logic [7:0] entrant_id;
  } frwa_in_t;

  // Result item.
  typedef struct packed {
    logic       granted;
    logic       grant_kind;
    logic [7:0] grant_id;
    logic [1:0] status;
    logic [5:0] queue_length;
    logic [5:0] readers_inside;
    logic       writer_inside;
  } frwa_out_t;

  // Command to the occupancy table: a search for a match, or an allocation.
  typedef struct packed {
    logic start;
    logic alloc;
  } frwa_tcmd_t;

  // Completion of a table command.
  typedef struct packed {
    logic done;
    logic hit;
  } frwa_trsp_t;

endpackage

>>> sv/fifo_fair_reader_writer_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_arbiter
// Starvation-free readers-writers admission arbiter with a waiting queue
// and an occupancy table, both held in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one item per operation: arrive (enqueue a reader
// or writer), depart (remove a matching occupant) or tick (try to admit the
// queue head). Every input item produces exactly one result item on the
// output channel with the grant, the status and the occupancy counts.
// Items are worked one at a time. Arrive, unused codes and a tick on an empty
// queue go straight to the result register. A tick on a non-empty queue first
// reads the head and, when it is eligible, searches the table for a free entry.
// A depart searches the table for a matching occupant; the table is walked one
// entry per cycle. The next item can be accepted as soon as the result
// register has been loaded.
// The result sits in an output register; the next item is accepted while it
// waits, and the block holds the following result internally until the
// receiver takes the pending one. Reset empties the queue and the table at
// once (valid bits in flip-flops); there is no clearing pass.
// ----------------------------------------------------------------------------
module fifo_fair_reader_writer_arbiter #(
  parameter int ENTRIES = 32,
  parameter int ID_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frwa_pkg::frwa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output frwa_pkg::frwa_out_t out_data_o
);
  import frwa_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int WW = ID_BITS + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [IW:0]   ENT_EXT  = (IW + 1)'(ENTRIES);
  localparam logic [CW-1:0] ENT_CNT  = CW'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_TBL,
    S_PUSH
  } state_e;

  state_e             state_q;
  logic [1:0]         op_q;
  logic               tk_q;
  logic [ID_BITS-1:0] tid_q;
  logic               granted_q;
  logic [1:0]         status_q;
  logic [IW-1:0]      head_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      readers_q;
  logic               writer_q;
  logic               out_valid_q;
  frwa_out_t          out_q;

  logic [WW-1:0]      fifo_mem [ENTRIES];
  logic [WW-1:0]      fifo_rd_q;

  logic               in_acc;
  logic [ID_BITS-1:0] in_id;
  logic [IW:0]        tail_sum;
  logic [IW-1:0]      tail_idx;
  logic               fifo_we;
  logic               head_kind;
  logic [ID_BITS-1:0] head_id;
  logic               eligible;
  logic [IW-1:0]      head_next;
  logic               out_free;
  frwa_tcmd_t         tcmd;
  frwa_trsp_t         trsp;

  // Handshake and input decoding.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_id      = ID_BITS'(in_data_i.entrant_id);
  assign out_free   = !out_valid_q || out_ready_i;

  // Queue tail address, wrapped by one compare and subtract.
  assign tail_sum = {1'b0, head_q} + (IW + 1)'(count_q);
  assign tail_idx = (tail_sum >= ENT_EXT) ? IW'(tail_sum - ENT_EXT) : tail_sum[IW-1:0];
  assign fifo_we  = in_acc && (in_data_i.operation == OP_ARRIVE) && (count_q != ENT_CNT);
  assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

  // Head entry and its admission rule.
  assign head_kind = fifo_rd_q[WW-1];
  assign head_id   = fifo_rd_q[ID_BITS-1:0];
  assign eligible  = (head_kind == KIND_READER) ? !writer_q
                                                : (!writer_q && (readers_q == '0));

  // Table commands: a depart starts a search, an eligible head an allocation.
  assign tcmd.start = (in_acc && (in_data_i.operation == OP_DEPART)) ||
                      ((state_q == S_HEAD) && eligible);
  assign tcmd.alloc = (state_q == S_HEAD);

  // Waiting queue memory with a registered read of the head.
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[tail_idx] <= {in_data_i.entrant_kind, in_id};
    end
    fifo_rd_q <= fifo_mem[head_q];
  end

  frwa_occ_table #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tcmd),
    .kind_i (tk_q),
    .id_i   (tid_q),
    .rsp_o  (trsp)
  );

  // Sequencer, counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ARRIVE;
      tk_q        <= KIND_READER;
      tid_q       <= '0;
      granted_q   <= 1'b0;
      status_q    <= ST_OK;
      head_q      <= '0;
      count_q     <= '0;
      readers_q   <= '0;
      writer_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // A taken result frees the output register unless a new one is loaded.
      if (out_valid_q && out_ready_i && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q      <= in_data_i.operation;
            tk_q      <= in_data_i.entrant_kind;
            tid_q     <= in_id;
            granted_q <= 1'b0;
            status_q  <= ST_OK;
            case (in_data_i.operation)
              OP_ARRIVE: begin
                if (count_q == ENT_CNT) begin
                  status_q <= ST_QFULL;
                end else begin
                  count_q <= count_q + 1'b1;
                end
                state_q <= S_PUSH;
              end
              OP_DEPART: begin
                state_q <= S_TBL;
              end
              OP_TICK: begin
                state_q <= (count_q == '0) ? S_PUSH : S_HEAD;
              end
              default: begin
                state_q <= S_PUSH;
              end
            endcase
          end
        end
        S_HEAD: begin
          tk_q    <= head_kind;
          tid_q   <= head_id;
          state_q <= eligible ? S_TBL : S_PUSH;
        end
        S_TBL: begin
          if (trsp.done) begin
            if (op_q == OP_DEPART) begin
              if (trsp.hit) begin
                if (tk_q == KIND_WRITER) begin
                  writer_q <= 1'b0;
                end else if (readers_q != '0) begin
                  readers_q <= readers_q - 1'b1;
                end
              end else begin
                status_q <= ST_NOTFOUND;
              end
            end else begin
              if (trsp.hit) begin
                granted_q <= 1'b1;
                if (tk_q == KIND_WRITER) begin
                  writer_q <= 1'b1;
                end else begin
                  readers_q <= readers_q + 1'b1;
                end
                head_q  <= head_next;
                count_q <= count_q - 1'b1;
              end else begin
                status_q <= ST_TFULL;
              end
            end
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_q.granted        <= granted_q;
            out_q.grant_kind     <= granted_q ? tk_q : KIND_READER;
            out_q.grant_id       <= granted_q ? 8'(tid_q) : 8'd0;
            out_q.status         <= status_q;
            out_q.queue_length   <= 6'(count_q);
            out_q.readers_inside <= 6'(readers_q);
            out_q.writer_inside  <= writer_q;
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A writer is never inside together with readers.
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(writer_q && (readers_q != '0)))
    else $error("writer admitted while readers are inside");

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ENT_CNT)
    else $error("queue count beyond depth");

  // The sequencer waits in the table state until the scan completes.
  a_tbl_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TBL) && !trsp.done |=> state_q == S_TBL)
    else $error("left table state before the scan completed");

  // A granted result always reports a clean status.
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> out_data_o.status == ST_OK)
    else $error("grant reported with an error status");
`endif

endmodule

>>> sv/frwa_occ_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwa_occ_table
// Occupancy table of admitted requesters. Kind and id live in a synchronous
// memory; valid bits live in flip-flops so reset empties the table at once.
// A search walks the memory one entry per cycle and frees the first match;
// an allocation walks the valid bits and fills the first free entry.
// ----------------------------------------------------------------------------
module frwa_occ_table #(
  parameter int ENTRIES = 32,
  parameter int ID_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frwa_pkg::frwa_tcmd_t  cmd_i,
  input  logic                  kind_i,
  input  logic [ID_BITS-1:0]    id_i,
  output frwa_pkg::frwa_trsp_t  rsp_o
);
  import frwa_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int WW = ID_BITS + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    T_IDLE,
    T_FIND,
    T_ALLOC
  } tstate_e;

  tstate_e           state_q;
  logic [IW-1:0]     rd_idx_q;
  logic [IW-1:0]     chk_idx_q;
  logic              chk_vld_q;
  logic              done_q;
  logic              hit_q;
  logic [ENTRIES-1:0] valid_q;
  logic [WW-1:0]     mem [ENTRIES];
  logic [WW-1:0]     rd_data_q;

  logic [WW-1:0]     key;
  logic              match;
  logic              free_hit;
  logic              clr;

  // Compare the entry read last cycle against the key; find a free entry.
  assign key      = {kind_i, id_i};
  assign match    = chk_vld_q && valid_q[chk_idx_q] && (rd_data_q == key);
  assign free_hit = (state_q == T_ALLOC) && !valid_q[rd_idx_q];
  assign clr      = (state_q == T_FIND) && match;

  // Valid bits, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (free_hit) begin
        valid_q[rd_idx_q] <= 1'b1;
      end
      if (clr) begin
        valid_q[chk_idx_q] <= 1'b0;
      end
    end
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (free_hit) begin
      mem[rd_idx_q] <= key;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  // Scan sequencer and registered response.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      rd_idx_q  <= '0;
      chk_idx_q <= '0;
      chk_vld_q <= 1'b0;
      done_q    <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        T_IDLE: begin
          chk_vld_q <= 1'b0;
          if (cmd_i.start) begin
            rd_idx_q <= '0;
            state_q  <= cmd_i.alloc ? T_ALLOC : T_FIND;
          end
        end
        T_FIND: begin
          chk_vld_q <= 1'b1;
          chk_idx_q <= rd_idx_q;
          if (rd_idx_q != LAST_IDX) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (match) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b1;
            state_q <= T_IDLE;
          end else if (chk_vld_q && (chk_idx_q == LAST_IDX)) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b0;
            state_q <= T_IDLE;
          end
        end
        T_ALLOC: begin
          if (free_hit) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b1;
            state_q <= T_IDLE;
          end else if (rd_idx_q == LAST_IDX) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b0;
            state_q <= T_IDLE;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hit  = hit_q;

`ifndef SYNTHESIS
  // A command only arrives while no scan is running.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> state_q == T_IDLE)
    else $error("table command while a scan is running");

  // Completion is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done)
    else $error("table completion longer than one cycle");

  // Completion only follows a scan.
  a_done_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> $past(state_q) != T_IDLE)
    else $error("table completion without a scan");
`endif

endmodule

>>> tb/tb_fifo_fair_reader_writer_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_fair_reader_writer_arbiter
// Self-checking bench for the fair readers-writers admission arbiter. A
// scoreboard class keeps its own copy of the waiting queue and the occupancy
// table. It computes the expected result of every accepted item and compares
// each returned result field by field. The stimulus starts with a directed
// walk through grants, blocked heads and failed departs. A fill phase follows
// that overflows the queue and the table while the output is held off. The
// rest is random arrive, tick and depart traffic, with bursty input and a
// stalling output.
// ----------------------------------------------------------------------------
module tb_fifo_fair_reader_writer_arbiter;
  import frwa_pkg::*;

  localparam int SLOTS        = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TIME  = SLOTS + 8;
  localparam int RANDOM_ITEMS = 430;
  // Operation code with no function in the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Predicts every result of the arbiter and holds the results still owed.
  class admission_scoreboard;
    bit        wait_kind [SLOTS];
    bit [7:0]  wait_id   [SLOTS];
    int        wait_head;
    int        wait_count;
    bit        occ_valid [SLOTS];
    bit        occ_kind  [SLOTS];
    bit [7:0]  occ_id    [SLOTS];
    int        readers_in;
    bit        writer_in;
    frwa_out_t owed_results[$];
    int        mismatches;

    // Apply one accepted item to the model state and queue its result.
    function void note_input(frwa_in_t item);
      frwa_out_t res;
      int        tail;
      int        slot;
      bit        head_kind;
      bit [7:0]  head_id;
      bit        eligible;
      res = '0;
      res.status = ST_OK;
      case (item.operation)
        OP_ARRIVE: begin
          if (wait_count >= SLOTS) begin
            res.status = ST_QFULL;
          end else begin
            tail = (wait_head + wait_count) % SLOTS;
            wait_kind[tail] = item.entrant_kind;
            wait_id[tail]   = item.entrant_id;
            wait_count++;
          end
        end
        OP_DEPART: begin
          res.status = ST_NOTFOUND;
          for (int i = 0; i < SLOTS; i++) begin
            if (occ_valid[i] && occ_kind[i] == item.entrant_kind &&
                occ_id[i] == item.entrant_id) begin
              occ_valid[i] = 1'b0;
              if (item.entrant_kind == KIND_WRITER) begin
                writer_in = 1'b0;
              end else if (readers_in > 0) begin
                readers_in--;
              end
              res.status = ST_OK;
              break;
            end
          end
        end
        OP_TICK: begin
          if (wait_count > 0) begin
            head_kind = wait_kind[wait_head];
            head_id   = wait_id[wait_head];
            if (head_kind == KIND_READER) begin
              eligible = !writer_in;
            end else begin
              eligible = !writer_in && readers_in == 0;
            end
            if (eligible) begin
              slot = -1;
              for (int i = 0; i < SLOTS; i++) begin
                if (!occ_valid[i]) begin
                  slot = i;
                  break;
                end
              end
              if (slot < 0) begin
                res.status = ST_TFULL;
              end else begin
                occ_valid[slot] = 1'b1;
                occ_kind[slot]  = head_kind;
                occ_id[slot]    = head_id;
                if (head_kind == KIND_WRITER) begin
                  writer_in = 1'b1;
                end else begin
                  readers_in++;
                end
                wait_head = (wait_head + 1) % SLOTS;
                wait_count--;
                res.granted    = 1'b1;
                res.grant_kind = head_kind;
                res.grant_id   = head_id;
              end
            end
          end
        end
        default: begin
        end
      endcase
      res.queue_length   = 6'(wait_count);
      res.readers_inside = 6'(readers_in);
      res.writer_inside  = writer_in;
      owed_results.push_back(res);
    endfunction

    // Compare one returned result with the oldest owed one.
    function void check_result(frwa_out_t got);
      frwa_out_t exp;
      bit        bad;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result %p with nothing owed", $realtime, got);
        end
        return;
      end
      exp = owed_results.pop_front();
      bad = (got.granted !== exp.granted) || (got.grant_kind !== exp.grant_kind) ||
            (got.grant_id !== exp.grant_id) || (got.status !== exp.status) ||
            (got.queue_length !== exp.queue_length) ||
            (got.readers_inside !== exp.readers_inside) ||
            (got.writer_inside !== exp.writer_inside);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %p", exp);
          $display("  actual   %p", got);
        end
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Choose one current occupant at random; returns 0 when the table is empty.
    function bit pick_occupant(output bit kind, output bit [7:0] id);
      int idx[$];
      int pick;
      kind = 1'b0;
      id   = '0;
      foreach (occ_valid[i]) begin
        if (occ_valid[i]) idx.push_back(i);
      end
      if (idx.size() == 0) return 1'b0;
      pick = idx[$urandom_range(0, idx.size() - 1)];
      kind = occ_kind[pick];
      id   = occ_id[pick];
      return 1'b1;
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  frwa_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  frwa_out_t out_data_o;

  admission_scoreboard sb = new();
  int cycle_count;
  int stall_request;
  int burst_left;

  fifo_fair_reader_writer_arbiter #(
    .ENTRIES(SLOTS),
    .ID_BITS(8)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Observe both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // Receiver: random stall pattern, plus long hold-offs on request.
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    hold_left   = 0;
    mode        = 0;
    mode_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = 1'($urandom_range(0, 1));
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted; called at a falling edge.
  // Between bursts the input usually goes idle for a random gap.
  task automatic offer(input logic [1:0] op, input logic kind, input logic [7:0] id);
    in_valid_i             = 1'b1;
    in_data_i.operation    = op;
    in_data_i.entrant_kind = kind;
    in_data_i.entrant_id   = id;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 15)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // Stop offering until every owed result has come back, then let the block settle.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_TIME) @(negedge clk_i);
  endtask

  // Random item: mostly arrivals, ticks and departs of real occupants.
  task automatic offer_random();
    int       pick;
    bit       kind;
    bit [7:0] id;
    pick = $urandom_range(0, 99);
    kind = 1'($urandom_range(0, 1));
    id   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    if (pick < 35) begin
      offer(OP_ARRIVE, kind, id);
    end else if (pick < 70) begin
      offer(OP_TICK, kind, id);
    end else if (pick < 95) begin
      if ($urandom_range(0, 4) != 0) void'(sb.pick_occupant(kind, id));
      offer(OP_DEPART, kind, id);
    end else begin
      offer(OP_UNUSED, kind, id);
    end
  endtask

  // Main stimulus.
  initial begin
    bit       kind;
    bit [7:0] id;
    cycle_count   = 0;
    stall_request = 0;
    burst_left    = 1;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    rst_ni        = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed walk: empty tick, unused code, failed departs, grants and
    // heads blocked by the other kind.
    offer(OP_TICK,   KIND_READER, 8'd0);
    offer(OP_UNUSED, KIND_WRITER, 8'd255);
    offer(OP_DEPART, KIND_READER, 8'd5);
    offer(OP_ARRIVE, KIND_READER, 8'd0);
    offer(OP_ARRIVE, KIND_WRITER, 8'd255);
    offer(OP_ARRIVE, KIND_READER, 8'd170);
    offer(OP_TICK,   KIND_READER, 8'd0);
    offer(OP_TICK,   KIND_READER, 8'd0);
    offer(OP_DEPART, KIND_WRITER, 8'd255);
    offer(OP_DEPART, KIND_READER, 8'd0);
    offer(OP_TICK,   KIND_WRITER, 8'd255);
    offer(OP_TICK,   KIND_READER, 8'd0);
    offer(OP_ARRIVE, KIND_WRITER, 8'd85);
    offer(OP_DEPART, KIND_WRITER, 8'd255);
    offer(OP_TICK,   KIND_READER, 8'd0);
    offer(OP_TICK,   KIND_READER, 8'd0);
    offer(OP_DEPART, KIND_READER, 8'd170);
    offer(OP_TICK,   KIND_READER, 8'd0);
    offer(OP_DEPART, KIND_WRITER, 8'd85);
    offer(OP_DEPART, KIND_WRITER, 8'd85);
    offer(OP_UNUSED, KIND_READER, 8'd0);

    // Fill phase with the output held off: overflow the queue, then fill
    // the table with readers until the next eligible head finds no room.
    stall_request = 300;
    repeat (SLOTS + 1) offer(OP_ARRIVE, KIND_READER, 8'($urandom_range(0, 255)));
    repeat (SLOTS) offer(OP_TICK, KIND_READER, 8'd0);
    offer(OP_ARRIVE, KIND_READER, 8'd1);
    offer(OP_ARRIVE, KIND_WRITER, 8'd2);
    offer(OP_TICK, KIND_READER, 8'd0);
    if (sb.pick_occupant(kind, id)) offer(OP_DEPART, kind, id);
    offer(OP_TICK, KIND_READER, 8'd0);
    while (sb.pick_occupant(kind, id)) offer(OP_DEPART, kind, id);
    offer(OP_TICK, KIND_READER, 8'd0);
    offer(OP_DEPART, KIND_WRITER, 8'd2);
    drain();

    // Random traffic, with one full pause halfway.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      offer_random();
      if (n == RANDOM_ITEMS / 2) drain();
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
